FILE: rtl/psmd_pkg.sv
// ----------------------------------------------------------------------------
// psmd_pkg
// Widths, modes and sideband types shared by the point/segment distance pipe.
// ----------------------------------------------------------------------------
package psmd_pkg;

    localparam int COORD_BITS  = 20;
    localparam int T_FRAC_BITS = 16;

    localparam int DIFF_W = COORD_BITS + 1;        // coordinate differences
    localparam int PROD_W = 2 * DIFF_W;            // one product, also len2
    localparam int LEN_W  = PROD_W;
    localparam int DOT_W  = PROD_W + 1;            // signed dot product
    localparam int REM_W  = LEN_W + 1;             // divider remainder
    localparam int Q_W    = T_FRAC_BITS + 1;       // t in [0, 2^T_FRAC_BITS]
    localparam int SC_W   = Q_W + 1 + DIFF_W;      // t * delta
    localparam int QC_W   = DIFF_W + 1;            // projected coordinate
    localparam int DIST_W = COORD_BITS + 1;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_END,
        MODE_INTERP
    } t_mode;

    typedef struct packed {
        t_mode                     mode;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [DIFF_W-1:0]     dx;
        logic signed [DIFF_W-1:0]     dy;
    } t_side;

endpackage

FILE: rtl/psmd_front.sv
// ----------------------------------------------------------------------------
// psmd_front
// Differences, products, len2/dot and clamp classification (three stages).
// ----------------------------------------------------------------------------
module psmd_front import psmd_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_valid,
    output logic [LEN_W-1:0]             o_num,
    output logic [LEN_W-1:0]             o_den,
    output t_side                        o_side
);

    logic                     r_v1, r_v2, r_v3;
    t_side                    r_side1, r_side2, r_side3;
    logic signed [DIFF_W-1:0] r_ux, r_uy;
    logic signed [PROD_W-1:0] r_dxdx, r_dydy, r_uxdx, r_uydy;
    logic [LEN_W-1:0]         r_num, r_den;

    logic [LEN_W-1:0]         n_len2;
    logic signed [DOT_W-1:0]  n_dot;
    t_mode                    n_mode;
    t_side                    n_side3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        n_len2 = LEN_W'($unsigned(r_dxdx)) + LEN_W'($unsigned(r_dydy));
        n_dot  = DOT_W'(r_uxdx) + DOT_W'(r_uydy);
        if (n_len2 == '0 || n_dot < 0) begin
            n_mode = MODE_START;
        end else if (n_dot > $signed({1'b0, n_len2})) begin
            n_mode = MODE_END;
        end else begin
            n_mode = MODE_INTERP;
        end
        n_side3      = r_side2;
        n_side3.mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1.mode <= MODE_START;
            r_side1.sx   <= i_start_x;
            r_side1.sy   <= i_start_y;
            r_side1.px   <= i_point_x;
            r_side1.py   <= i_point_y;
            r_side1.dx   <= DIFF_W'(i_end_x) - DIFF_W'(i_start_x);
            r_side1.dy   <= DIFF_W'(i_end_y) - DIFF_W'(i_start_y);
            r_ux         <= DIFF_W'(i_point_x) - DIFF_W'(i_start_x);
            r_uy         <= DIFF_W'(i_point_y) - DIFF_W'(i_start_y);

            r_side2 <= r_side1;
            r_dxdx  <= r_side1.dx * r_side1.dx;
            r_dydy  <= r_side1.dy * r_side1.dy;
            r_uxdx  <= r_ux * r_side1.dx;
            r_uydy  <= r_uy * r_side1.dy;

            r_side3 <= n_side3;
            // only an in-range dot reaches the divider as a real numerator
            r_num <= (n_mode == MODE_INTERP) ? n_dot[LEN_W-1:0] : '0;
            r_den <= (n_mode == MODE_INTERP) ? n_len2 : LEN_W'(1);
        end
    end

    assign o_valid = r_v3;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side3;

endmodule

FILE: rtl/psmd_div.sv
// ----------------------------------------------------------------------------
// psmd_div
// Pipelined restoring divider: floor(num * 2^T_FRAC_BITS / den), num <= den.
// One quotient bit per stage, Q_W stages.
// ----------------------------------------------------------------------------
module psmd_div import psmd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [LEN_W-1:0] i_num,
    input  logic [LEN_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_t,
    output t_side            o_side
);

    logic             r_vld  [Q_W];
    logic [REM_W-1:0] r_rem  [Q_W];
    logic [Q_W-1:0]   r_quo  [Q_W];
    logic [LEN_W-1:0] r_den  [Q_W];
    t_side            r_side [Q_W];

    logic             n_ge0;

    assign n_ge0 = (i_num >= i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_ge0 ? REM_W'(i_num - i_den) : REM_W'(i_num);
            r_quo[0]  <= Q_W'(n_ge0);
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 1; g < Q_W; g++) begin : g_stage
        logic [REM_W-1:0] n_sh;
        logic             n_ge;

        assign n_sh = {r_rem[g-1][REM_W-2:0], 1'b0};
        assign n_ge = (n_sh >= REM_W'(r_den[g-1]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_ge ? n_sh - REM_W'(r_den[g-1]) : n_sh;
                r_quo[g]  <= {r_quo[g-1][Q_W-2:0], n_ge};
                r_den[g]  <= r_den[g-1];
                r_side[g] <= r_side[g-1];
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_t     = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

FILE: rtl/psmd_back.sv
// ----------------------------------------------------------------------------
// psmd_back
// Scales delta by t, clamps the projection and sums the axis distances.
// ----------------------------------------------------------------------------
module psmd_back import psmd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [Q_W-1:0]    i_t,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [DIST_W-1:0] o_distance
);

    localparam logic [DIST_W:0] DIST_MAX = {1'b0, {DIST_W{1'b1}}};

    logic                   r_va, r_vb, r_vc;
    t_side                  r_side;
    logic signed [SC_W-1:0] r_prod_x, r_prod_y;
    logic [QC_W-1:0]        r_ax, r_ay;
    logic [DIST_W-1:0]      r_dist;

    logic signed [QC_W-1:0]   n_offx, n_offy, n_qx, n_qy;
    logic signed [QC_W:0]     n_ex, n_ey;
    logic [DIST_W:0]          n_sum;

    always_comb begin
        // arithmetic shift gives the floor for both signs of delta
        n_offx = QC_W'(r_prod_x >>> T_FRAC_BITS);
        n_offy = QC_W'(r_prod_y >>> T_FRAC_BITS);
        case (r_side.mode)
            MODE_END: begin
                n_qx = QC_W'(r_side.sx) + QC_W'(r_side.dx);
                n_qy = QC_W'(r_side.sy) + QC_W'(r_side.dy);
            end
            MODE_INTERP: begin
                n_qx = QC_W'(r_side.sx) + n_offx;
                n_qy = QC_W'(r_side.sy) + n_offy;
            end
            default: begin
                n_qx = QC_W'(r_side.sx);
                n_qy = QC_W'(r_side.sy);
            end
        endcase
        n_ex  = (QC_W+1)'(r_side.px) - (QC_W+1)'(n_qx);
        n_ey  = (QC_W+1)'(r_side.py) - (QC_W+1)'(n_qy);
        n_sum = (DIST_W+1)'(r_ax) + (DIST_W+1)'(r_ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side   <= i_side;
            r_prod_x <= $signed({1'b0, i_t}) * i_side.dx;
            r_prod_y <= $signed({1'b0, i_t}) * i_side.dy;

            r_ax <= QC_W'(n_ex < 0 ? -n_ex : n_ex);
            r_ay <= QC_W'(n_ey < 0 ? -n_ey : n_ey);

            r_dist <= (n_sum > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : n_sum[DIST_W-1:0];
        end
    end

    assign o_valid    = r_vc;
    assign o_distance = r_dist;

endmodule

FILE: rtl/point_segment_manhattan_distance_unit.sv
// ----------------------------------------------------------------------------
// point_segment_manhattan_distance_unit
// Manhattan distance from a point to its clamped projection on a segment.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with start, end and point coordinates,
//   signed Q12.8. A transfer happens on a clock edge with i_valid high and
//   o_stall low. Output channel: o_valid / i_stall with o_distance, Q13.8.
//   The pipe has 3 front stages (differences, products, len2/dot),
//   17 divider stages (one quotient bit each), 3 back stages (scale,
//   projection, sum). Throughput is one item per cycle while no stall holds it.
//   The whole pipe advances as one: when the output holds a result and the
//   receiver stalls, every stage freezes and o_stall goes high, so nothing
//   is lost or repeated. Bubbles are not squeezed out.
//   Synchronous active-low reset clears all valid bits; data registers are
//   not reset.
// ----------------------------------------------------------------------------
module point_segment_manhattan_distance_unit import psmd_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [DIST_W-1:0]            o_distance
);

    logic             w_en;
    logic             w_f_valid, w_d_valid;
    logic [LEN_W-1:0] w_num, w_den;
    t_side            w_f_side, w_d_side;
    logic [Q_W-1:0]   w_t;

    assign o_stall = o_valid & i_stall;
    assign w_en    = ~o_stall;

    psmd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .o_valid   (w_f_valid),
        .o_num     (w_num),
        .o_den     (w_den),
        .o_side    (w_f_side)
    );

    psmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (w_f_side),
        .o_valid (w_d_valid),
        .o_t     (w_t),
        .o_side  (w_d_side)
    );

    psmd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_d_valid),
        .i_t        (w_t),
        .i_side     (w_d_side),
        .o_valid    (o_valid),
        .o_distance (o_distance)
    );

    // projection stays on the segment, so the sum never saturates
    a_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distance != {DIST_W{1'b1}})
        else $error("distance reached saturation");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a pending result");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d_valid |-> w_t <= Q_W'(1) << T_FRAC_BITS)
        else $error("projection parameter above one");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

FILE: tb/point_segment_manhattan_distance_unit_test.sv
// ----------------------------------------------------------------------------
// point_segment_manhattan_distance_unit_test
// Drives segment/point queries through the distance pipe, computes the
// expected clamped-projection Manhattan distance in a scoreboard and checks
// every output transfer in order, under several idle/stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class distance_scoreboard;
    logic [psmd_pkg::DIST_W-1:0] pending[$];
    int errors = 0;

    function automatic logic [psmd_pkg::DIST_W-1:0] distance_of(
        logic signed [19:0] sx, logic signed [19:0] sy,
        logic signed [19:0] ex, logic signed [19:0] ey,
        logic signed [19:0] px, logic signed [19:0] py);
        longint dx, dy, ux, uy, dot, qx, qy, adx, ady;
        longint unsigned len2, t, r, q, mag, prod, sum;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        ux = longint'(px) - longint'(sx);
        uy = longint'(py) - longint'(sy);
        len2 = dx * dx + dy * dy;
        dot = ux * dx + uy * dy;
        if (len2 == 0 || dot < 0) begin
            qx = sx; qy = sy;
        end else if (longint'(dot) > longint'(len2)) begin
            qx = ex; qy = ey;
        end else begin
            // restoring division, one quotient bit per step
            r = dot; q = 0;
            if (r >= len2) begin r -= len2; q = 1; end
            for (int i = 0; i < psmd_pkg::T_FRAC_BITS; i++) begin
                r = r << 1; q = q << 1;
                if (r >= len2) begin r -= len2; q |= 1; end
            end
            t = q;
            if (dx >= 0) qx = sx + longint'((t * dx) >> psmd_pkg::T_FRAC_BITS);
            else begin
                mag = -dx; prod = (t * mag + 65535) >> psmd_pkg::T_FRAC_BITS;
                qx = sx - longint'(prod);
            end
            if (dy >= 0) qy = sy + longint'((t * dy) >> psmd_pkg::T_FRAC_BITS);
            else begin
                mag = -dy; prod = (t * mag + 65535) >> psmd_pkg::T_FRAC_BITS;
                qy = sy - longint'(prod);
            end
        end
        adx = px - qx; if (adx < 0) adx = -adx;
        ady = py - qy; if (ady < 0) ady = -ady;
        sum = adx + ady;
        if (sum > 64'h1FFFFF) sum = 64'h1FFFFF;
        return sum[psmd_pkg::DIST_W-1:0];
    endfunction

    function void note_query(logic signed [19:0] sx, logic signed [19:0] sy,
        logic signed [19:0] ex, logic signed [19:0] ey,
        logic signed [19:0] px, logic signed [19:0] py);
        pending.push_back(distance_of(sx, sy, ex, ey, px, py));
    endfunction

    function void check_distance(logic [psmd_pkg::DIST_W-1:0] got);
        logic [psmd_pkg::DIST_W-1:0] want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected distance %0d", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (want !== got) begin
            $display("%0t: distance expected %0d actual %0d", $time, want, got);
            errors++;
        end
    endfunction
endclass

module point_segment_manhattan_distance_unit_test;
    import psmd_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [COORD_BITS-1:0] i_start_x = '0, i_start_y = '0;
    logic signed [COORD_BITS-1:0] i_end_x = '0, i_end_y = '0;
    logic signed [COORD_BITS-1:0] i_point_x = '0, i_point_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [DIST_W-1:0] o_distance;

    distance_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;

    point_segment_manhattan_distance_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: stall pattern, long hold-off when requested
    always @(posedge i_clk) begin
        if (o_valid && !i_stall && i_rst_n) board.check_distance(o_distance);
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic signed [19:0] rand_coord();
        case ($urandom_range(3))
            0: return 20'($urandom);
            1: return $signed(20'($urandom_range(0, 2047))) - 20'sd1024;
            2: return $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
            default: return $signed(20'($urandom)) >>> $urandom_range(19);
        endcase
    endfunction

    task automatic send_query(logic signed [19:0] sx, logic signed [19:0] sy,
        logic signed [19:0] ex, logic signed [19:0] ey,
        logic signed [19:0] px, logic signed [19:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_x <= sx; i_start_y <= sy; i_end_x <= ex; i_end_y <= ey;
        i_point_x <= px; i_point_y <= py;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_query(sx, sy, ex, ey, px, py);
    endtask

    task automatic send_random(int count);
        logic signed [19:0] sx, sy, ex, ey;
        for (int n = 0; n < count; n++) begin
            sx = rand_coord(); sy = rand_coord();
            if ($urandom_range(9) == 0) begin ex = sx; ey = sy; end
            else begin ex = rand_coord(); ey = rand_coord(); end
            send_query(sx, sy, ex, ey, rand_coord(), rand_coord());
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: degenerate, behind start, beyond end, exact end, interior, extremes
        send_query(20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd100, -20'sd50);
        send_query(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 20'sh80000, 20'sh80000, 20'sh7FFFF);
        send_query(20'sd0, 20'sd0, 20'sd256, 20'sd0, -20'sd512, 20'sd30);
        send_query(20'sd0, 20'sd0, 20'sd256, 20'sd0, 20'sd1000, -20'sd30);
        send_query(20'sd0, 20'sd0, 20'sd256, 20'sd256, 20'sd256, 20'sd256);
        send_query(20'sd0, 20'sd0, 20'sd256, 20'sd256, 20'sd128, 20'sd0);
        send_query(20'sd10, 20'sd20, -20'sd300, 20'sd77, -20'sd40, 20'sd500);
        send_query(20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh80000);
        send_query(20'sh7FFFF, 20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sd0, 20'sd0);
        send_query(20'sh80000, 20'sh7FFFF, 20'sh7FFFF, 20'sh80000, 20'sh80000, 20'sh80000);
        send_query(20'sh80000, 20'sd0, 20'sh7FFFF, 20'sd0, 20'sh7FFFF, 20'sh7FFFF);
        send_query(20'sd0, 20'sh7FFFF, 20'sd0, 20'sh80000, 20'sh80000, 20'sd1);
        send_query(20'shFFFFF, 20'shFFFFF, 20'sd1, 20'sd1, 20'shAAAAA, 20'sh55555);
        send_query(-20'sd3, 20'sd5, -20'sd3, -20'sd7, 20'sd9, -20'sd1);
        send_random(400);
        drain();    // sender pauses until all results are in
        send_idle_pct = 87;
        send_random(300);
        send_idle_pct = 0; recv_stall_pct = 87;
        send_random(300);
        recv_stall_pct = 0;
        hold_off_cycles = 200;   // pipe fills and stalls the input
        send_random(250);
        send_idle_pct = 32; recv_stall_pct = 32;
        send_random(400);
        send_idle_pct = 0; recv_stall_pct = 0;
        send_random(286);
        drain();
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("point_segment_manhattan_distance_unit_test OK");
        else
            $display("point_segment_manhattan_distance_unit_test NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("point_segment_manhattan_distance_unit_test NOT OK");
        $finish;
    end
endmodule
